>>> rtl/core/btffa_pkg.sv
// ----------------------------------------------------------------------------
// btffa_pkg
// Shared constants, types and helpers for the boundary-tag allocator.
// ----------------------------------------------------------------------------
package btffa_pkg;

	localparam int HEAP_SIZE = 4096;
	localparam int MIN_BLOCK = 32;
	localparam int TAG_BYTES = 8;
	localparam int TWO_TAGS  = 2 * TAG_BYTES;

	// field widths at the ports
	localparam int REQ_W = 13;
	localparam int OFF_W = 12;

	localparam int ADDR_W = $clog2(HEAP_SIZE);   // tag store index
	localparam int SIZE_W = ADDR_W + 1;          // block size, up to HEAP_SIZE
	localparam int TAG_W  = SIZE_W + 1;          // size plus busy flag
	localparam int EXT_W  = SIZE_W + 1;          // sums of offsets and sizes

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [EXT_W-1:0]  ext_t;

	typedef struct packed {
		size_t size;
		logic  busy;
	} tag_t;

	localparam ext_t  HEAP_X     = EXT_W'(HEAP_SIZE);
	localparam ext_t  MIN_X      = EXT_W'(MIN_BLOCK);
	localparam ext_t  TAG_X      = EXT_W'(TAG_BYTES);
	localparam ext_t  TWO_TAGS_X = EXT_W'(TWO_TAGS);
	localparam addr_t FTR_INIT   = ADDR_W'(HEAP_SIZE - TAG_BYTES);
	localparam tag_t  INIT_TAG   = '{size: SIZE_W'(HEAP_SIZE), busy: 1'b0};

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;
	localparam logic STAT_OK      = 1'b0;
	localparam logic STAT_FAIL    = 1'b1;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_A_RD,
		S_A_EVAL,
		S_A_SPLIT,
		S_R_RD,
		S_R_GET,
		S_R_NCHK,
		S_R_RDN,
		S_R_GETN,
		S_R_PCHK,
		S_R_RDP,
		S_R_GETP,
		S_R_RDV,
		S_R_GETV,
		S_W_HDR,
		S_W_FTR,
		S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_RD_HDR,
		OP_RD_NXT,
		OP_RD_PFT,
		OP_RD_PRV,
		OP_FAIL,
		OP_TAKE,
		OP_STEP,
		OP_SPLIT,
		OP_REL_SET,
		OP_MERGE_N,
		OP_PRV,
		OP_MERGE_P,
		OP_WR_HDR,
		OP_WR_FTR
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;   // clearing sweep at last entry
		logic rel_low;    // release offset below first header
		logic rd_zero;    // tag read back has size zero
		logic fits;       // tag read back is free and big enough
		logic walk_end;   // next header would be past the heap
		logic split;      // chosen block gets split
		logic nxt_ok;     // a right neighbour exists
		logic prv_chk;    // worth looking for a left neighbour
		logic prv_ok;     // left footer names a real neighbour
		logic rd_busy;    // busy flag of tag read back
	} st_t;

	// limit a block size so the block ends at or before the heap end
	function automatic size_t clamp_size(addr_t hdr, ext_t x);
		ext_t room;
		room = HEAP_X - EXT_W'(hdr);
		return (x > room) ? SIZE_W'(room) : SIZE_W'(x);
	endfunction

endpackage

>>> rtl/core/btffa_ram.sv
// ----------------------------------------------------------------------------
// btffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module btffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/btffa_ctrl.sv
// ----------------------------------------------------------------------------
// btffa_ctrl
// Sequencer for clear, first-fit walk, split and release/merge steps.
// ----------------------------------------------------------------------------
module btffa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             func,
	input  btffa_pkg::st_t   st,
	output btffa_pkg::cmd_t  cmd,
	output logic             busy,
	output logic             done
);

	import btffa_pkg::*;

	state_t state_q, state_d;
	state_t ret_q, ret_d;   // where to go after a header/footer pair

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q   <= S_DONE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE, S_DONE: begin
				state_d = S_IDLE;
				if (start) begin
					cmd.op = OP_LOAD;
					if (func == FUNC_ALLOC) begin
						state_d = S_A_RD;
					end else if (st.rel_low) begin
						state_d = S_DONE;
					end else begin
						state_d = S_R_RD;
					end
				end
			end
			S_A_RD: begin
				cmd.op  = OP_RD_HDR;
				state_d = S_A_EVAL;
			end
			S_A_EVAL: begin
				if (st.rd_zero) begin
					cmd.op  = OP_FAIL;
					state_d = S_DONE;
				end else if (st.fits) begin
					cmd.op  = OP_TAKE;
					state_d = S_W_HDR;
					ret_d   = S_A_SPLIT;
				end else if (st.walk_end) begin
					cmd.op  = OP_FAIL;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_STEP;
					state_d = S_A_RD;
				end
			end
			S_A_SPLIT: begin
				if (st.split) begin
					cmd.op  = OP_SPLIT;
					state_d = S_W_HDR;
					ret_d   = S_DONE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_R_RD: begin
				cmd.op  = OP_RD_HDR;
				state_d = S_R_GET;
			end
			S_R_GET: begin
				cmd.op  = OP_REL_SET;
				state_d = S_W_HDR;
				ret_d   = S_R_NCHK;
			end
			S_R_NCHK: begin
				state_d = st.nxt_ok ? S_R_RDN : S_R_PCHK;
			end
			S_R_RDN: begin
				cmd.op  = OP_RD_NXT;
				state_d = S_R_GETN;
			end
			S_R_GETN: begin
				if (st.rd_busy) begin
					state_d = S_R_PCHK;
				end else begin
					cmd.op  = OP_MERGE_N;
					state_d = S_W_HDR;
					ret_d   = S_R_PCHK;
				end
			end
			S_R_PCHK: begin
				state_d = st.prv_chk ? S_R_RDP : S_DONE;
			end
			S_R_RDP: begin
				cmd.op  = OP_RD_PFT;
				state_d = S_R_GETP;
			end
			S_R_GETP: begin
				if (st.prv_ok) begin
					cmd.op  = OP_PRV;
					state_d = S_R_RDV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_R_RDV: begin
				cmd.op  = OP_RD_PRV;
				state_d = S_R_GETV;
			end
			S_R_GETV: begin
				if (st.rd_busy) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_MERGE_P;
					state_d = S_W_HDR;
					ret_d   = S_DONE;
				end
			end
			S_W_HDR: begin
				cmd.op  = OP_WR_HDR;
				state_d = S_W_FTR;
			end
			S_W_FTR: begin
				cmd.op  = OP_WR_FTR;
				state_d = ret_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = !(state_q == S_IDLE || state_q == S_DONE);
	assign done = (state_q == S_DONE);

	// busy only drops at a result, or when the clearing sweep ends
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done || $past(state_q == S_CLEAR))
		else $error("busy dropped without a result");

	// an accepted item always leads to work or to its result
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy || done)
		else $error("accepted item dropped");

	// a tag pair is only written for a known follow-up step
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_W_FTR) |-> (ret_q == S_A_SPLIT || ret_q == S_R_NCHK ||
			ret_q == S_R_PCHK || ret_q == S_DONE))
		else $error("bad return state");

endmodule

>>> rtl/core/btffa_dp.sv
// ----------------------------------------------------------------------------
// btffa_dp
// Tag store, walk and merge arithmetic, result registers.
// ----------------------------------------------------------------------------
module btffa_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            func,
	input  logic [btffa_pkg::REQ_W-1:0]     request_size,
	input  logic [btffa_pkg::OFF_W-1:0]     release_offset,
	input  btffa_pkg::cmd_t                 cmd,
	output btffa_pkg::st_t                  st,
	output logic                            status,
	output logic [btffa_pkg::OFF_W-1:0]     payload_offset
);

	import btffa_pkg::*;

	// control registers
	addr_t               clr_q;
	logic                status_q;
	logic [OFF_W-1:0]    payload_q;
	logic                split_q;

	// working registers
	addr_t hdr_q;     // current header (walk) or released header
	ext_t  want_q;    // padded request size
	size_t size_q;    // size of the block being released
	addr_t prv_q;     // left neighbour header
	ext_t  blk_q;     // header offset of the pending tag pair
	size_t bsz_q;     // size of the pending tag pair
	logic  bbusy_q;   // busy flag of the pending tag pair
	size_t rest_q;    // split remainder

	// RAM port
	logic                ram_we, ram_re;
	addr_t               ram_waddr, ram_raddr;
	logic [TAG_W-1:0]    ram_wdata, ram_rdata;

	tag_t              rd_tag;
	ext_t              rd_sz, hdr_x, size_x, walk_sum, nxt_sum, rest, req_sum, want_d;
	logic [EXT_W:0]    fend;
	logic              ftr_ok;
	addr_t             ftr_addr;
	size_t             take, merge_n, merge_p;

	btffa_ram #(
		.WIDTH (TAG_W),
		.DEPTH (HEAP_SIZE)
	) u_tags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_tag   = tag_t'(ram_rdata);
	assign rd_sz    = EXT_W'(rd_tag.size);
	assign hdr_x    = EXT_W'(hdr_q);
	assign size_x   = EXT_W'(size_q);
	assign walk_sum = hdr_x + rd_sz;
	assign nxt_sum  = hdr_x + size_x;
	assign rest     = rd_sz - want_q;
	assign take     = (rest < MIN_X) ? rd_tag.size : SIZE_W'(want_q);
	assign req_sum  = EXT_W'(request_size) + TWO_TAGS_X;
	assign want_d   = (req_sum < MIN_X) ? MIN_X : req_sum;
	assign merge_n  = clamp_size(hdr_q, size_x + rd_sz);
	assign merge_p  = clamp_size(prv_q, rd_sz + size_x);

	// footer sits at end - TAG_BYTES; skipped when outside the heap
	assign fend     = {1'b0, blk_q} + (EXT_W + 1)'(bsz_q);
	assign ftr_ok   = (fend >= (EXT_W + 1)'(TAG_BYTES)) &&
		(fend < (EXT_W + 1)'(HEAP_SIZE + TAG_BYTES));
	assign ftr_addr = ADDR_W'(fend - (EXT_W + 1)'(TAG_BYTES));

	always_comb begin
		st.clr_last = (clr_q == ADDR_W'(HEAP_SIZE - 1));
		st.rel_low  = (release_offset < OFF_W'(TAG_BYTES));
		st.rd_zero  = (rd_tag.size == '0);
		st.fits     = !rd_tag.busy && (rd_sz >= want_q);
		st.walk_end = (walk_sum >= HEAP_X);
		st.split    = split_q;
		st.nxt_ok   = (size_q != '0) && (nxt_sum < HEAP_X);
		st.prv_chk  = (hdr_x >= TAG_X) && (size_q != '0);
		st.prv_ok   = (rd_tag.size != '0) && (rd_sz <= hdr_x);
		st.rd_busy  = rd_tag.busy;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = blk_q[ADDR_W-1:0];
		ram_wdata = {bsz_q, bbusy_q};
		ram_re    = 1'b0;
		ram_raddr = hdr_q;
		unique case (cmd.op)
			OP_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = (clr_q == '0 || clr_q == FTR_INIT) ? INIT_TAG : '0;
			end
			OP_RD_HDR: begin
				ram_re = 1'b1;
			end
			OP_RD_NXT: begin
				ram_re    = 1'b1;
				ram_raddr = nxt_sum[ADDR_W-1:0];
			end
			OP_RD_PFT: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(hdr_x - TAG_X);
			end
			OP_RD_PRV: begin
				ram_re    = 1'b1;
				ram_raddr = prv_q;
			end
			OP_WR_HDR: begin
				ram_we = (blk_q < HEAP_X);
			end
			OP_WR_FTR: begin
				ram_we    = ftr_ok;
				ram_waddr = ftr_addr;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			status_q  <= STAT_OK;
			payload_q <= '0;
			split_q   <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				OP_LOAD: begin
					status_q  <= STAT_OK;
					payload_q <= '0;
				end
				OP_FAIL: begin
					status_q  <= STAT_FAIL;
					payload_q <= '0;
				end
				OP_TAKE: begin
					status_q  <= STAT_OK;
					payload_q <= OFF_W'(hdr_x + TAG_X);
					split_q   <= (rest >= MIN_X);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				hdr_q  <= (func == FUNC_ALLOC) ? '0 :
					ADDR_W'(release_offset - OFF_W'(TAG_BYTES));
				want_q <= want_d;
			end
			OP_TAKE: begin
				blk_q   <= hdr_x;
				bsz_q   <= take;
				bbusy_q <= 1'b1;
				rest_q  <= SIZE_W'(rest);
			end
			OP_STEP: begin
				hdr_q <= walk_sum[ADDR_W-1:0];
			end
			OP_SPLIT: begin
				blk_q   <= blk_q + EXT_W'(bsz_q);
				bsz_q   <= rest_q;
				bbusy_q <= 1'b0;
			end
			OP_REL_SET: begin
				size_q  <= rd_tag.size;
				blk_q   <= hdr_x;
				bsz_q   <= rd_tag.size;
				bbusy_q <= 1'b0;
			end
			OP_MERGE_N: begin
				size_q  <= merge_n;
				blk_q   <= hdr_x;
				bsz_q   <= merge_n;
				bbusy_q <= 1'b0;
			end
			OP_PRV: begin
				prv_q <= ADDR_W'(hdr_x - rd_sz);
			end
			OP_MERGE_P: begin
				blk_q   <= EXT_W'(prv_q);
				bsz_q   <= merge_p;
				bbusy_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign status         = status_q;
	assign payload_offset = payload_q;

	// single RAM port discipline: no read in a write cycle
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("tag read and write in the same cycle");

	// a failed allocate never reports an offset
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == STAT_FAIL) |-> (payload_q == '0))
		else $error("offset reported on failure");

	// the first-fit walk always moves forward
	a_walk_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_STEP) |=> (hdr_q > $past(hdr_q)))
		else $error("walk did not advance");

endmodule

>>> rtl/core/boundary_tag_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator
// First-fit heap allocator with boundary tags and coalescing on release.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the 4096-entry tag store once, one entry
// per cycle, with busy high until the sweep ends and the first item can be
// taken. An item is taken on a clock edge with start high and busy low; its
// single result appears on status/payload_offset with done high for exactly
// one cycle, and there is no way to hold it off - capture it then. Each item
// is paced by the tag store (one tag read or write per cycle, read data
// registered): allocate reads and tests one header per block visited and, on
// a fit, writes a header/footer pair, plus a second pair for a split; release
// reads its header, writes its pair, may read and merge the right and then
// the left neighbour, and goes straight to its result when the offset is below
// the first header. A new item may be started in the done cycle itself.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            func,
	input  logic [btffa_pkg::REQ_W-1:0]     request_size,
	input  logic [btffa_pkg::OFF_W-1:0]     release_offset,
	output logic                            done,
	output logic                            status,
	output logic [btffa_pkg::OFF_W-1:0]     payload_offset
);

	import btffa_pkg::*;

	// controller and datapath talk only through these two bundles
	cmd_t cmd;
	st_t  st;

	btffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// tag store plus the size/offset arithmetic for walk, split and merges
	btffa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.func           (func),
		.request_size   (request_size),
		.release_offset (release_offset),
		.cmd            (cmd),
		.st             (st),
		.status         (status),
		.payload_offset (payload_offset)
	);

endmodule
